>>> rtl/core/ghtm_pkg.sv
package ghtm_pkg;

  localparam int POS_BITS  = 24;
  localparam int WIN_BITS  = 24;
  localparam int IDX_BITS  = 5;
  localparam int DIST_BITS = 25;

  localparam logic [1:0] OP_LOAD_HIT   = 2'd0;
  localparam logic [1:0] OP_LOAD_TRUTH = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  localparam logic [2:0] ADDR_WINDOW_U = 3'd0;
  localparam logic [2:0] ADDR_WINDOW_V = 3'd4;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 24'd13107;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [POS_BITS-1:0] pos_u;
    logic signed [POS_BITS-1:0] pos_v;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  hit_index;
    logic                 matched;
    logic [IDX_BITS-1:0]  truth_index;
    logic [DIST_BITS-1:0] match_distance;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/core/greedy_hit_truth_matcher.sv
// Greedy hit-to-truth matcher. Hits (operation 0) and true positions
// (operation 1) load one item per cycle; loads past MAX_HITS or MAX_TRUTHS
// are dropped. Since a true position may serve several hits, every hit ends
// up with its own nearest true position inside the windows (first in load
// order on a tie), so a run (operation 2) streams the true positions once
// from the truth memory through a row of MAX_HITS hit cells, one position
// per cycle. A run streams the positions and lets the row settle, then the
// hit results shift out of the row in hit order, gated by out_ready. The
// input is taken only between runs.
module greedy_hit_truth_matcher #(
  parameter int MAX_HITS   = 32,
  parameter int MAX_TRUTHS = 32,
  parameter int COORD_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghtm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghtm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import ghtm_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int TAW   = $clog2(MAX_TRUTHS);
  localparam int HCW   = $clog2(MAX_HITS + 1);
  localparam int TCW   = $clog2(MAX_TRUTHS + 1);
  localparam int DW    = (CB + 1 > WIN_BITS) ? CB + 1 : WIN_BITS;
  localparam int DISTW = DW + 1;
  localparam int DRAIN = MAX_HITS + 4;
  localparam int DCW   = $clog2(DRAIN + 1);

  typedef enum logic [1:0] {S_IDLE, S_STREAM, S_DRAIN, S_OUTPUT} state_t;

  state_t              state_r;
  logic [WIN_BITS-1:0] window_u_r, window_v_r;
  logic [HCW-1:0]      hit_cnt_r;
  logic [TCW-1:0]      truth_cnt_r, rd_cnt_r;
  logic [DCW-1:0]      drain_cnt_r;
  logic [HCW-1:0]      out_cnt_r;
  logic                issue_r;
  logic [TAW-1:0]      issue_idx_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic                accept, cfg_wr;
  logic [CB-1:0]       in_u, in_v;
  logic                truth_we;
  logic [2*CB-1:0]     rdata;
  logic                take_out;
  cell_ctl_t           ctl [MAX_HITS];

  logic                tv   [MAX_HITS+1];
  logic [CB-1:0]       tu_c [MAX_HITS+1];
  logic [CB-1:0]       tv_c [MAX_HITS+1];
  logic [TAW-1:0]      ti_c [MAX_HITS+1];
  logic                rf   [MAX_HITS+1];
  logic [TAW-1:0]      ri   [MAX_HITS+1];
  logic [DISTW-1:0]    rd   [MAX_HITS+1];

  function automatic logic [CB-1:0] to_coord(logic signed [POS_BITS-1:0] p);
    logic signed [63:0] ext;
    ext = 64'(p);
    return ext[CB-1:0];
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_u     = to_coord(in_data.pos_u);
  assign in_v     = to_coord(in_data.pos_v);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign truth_we = accept && (in_data.operation == OP_LOAD_TRUTH)
                    && (truth_cnt_r < TCW'(MAX_TRUTHS));
  assign take_out = (state_r == S_OUTPUT) && (out_cnt_r != hit_cnt_r)
                    && (!out_valid_r || out_ready);

  always_comb begin
    case (paddr)
      ADDR_WINDOW_U: prdata = 32'(window_u_r);
      ADDR_WINDOW_V: prdata = 32'(window_v_r);
      default:       prdata = '0;
    endcase
  end

  ghtm_ram #(.WIDTH(2 * CB), .DEPTH(MAX_TRUTHS)) u_truth_ram (
    .clk   (clk),
    .we    (truth_we),
    .waddr (truth_cnt_r[TAW-1:0]),
    .wdata ({in_u, in_v}),
    .raddr (rd_cnt_r[TAW-1:0]),
    .rdata (rdata)
  );

  assign tv[0]   = issue_r;
  assign tu_c[0] = rdata[2*CB-1:CB];
  assign tv_c[0] = rdata[CB-1:0];
  assign ti_c[0] = issue_idx_r;
  assign rf[MAX_HITS] = 1'b0;
  assign ri[MAX_HITS] = '0;
  assign rd[MAX_HITS] = '0;

  for (genvar k = 0; k < MAX_HITS; k++) begin : g_row
    always_comb begin
      ctl[k].load  = accept && (in_data.operation == OP_LOAD_HIT)
                     && (hit_cnt_r == HCW'(k));
      ctl[k].clear = accept && (in_data.operation == OP_RUN);
      ctl[k].shift = take_out;
    end

    ghtm_cell #(.CB(CB), .TAW(TAW)) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl[k]),
      .load_u        (in_u),
      .load_v        (in_v),
      .win_u         (window_u_r),
      .win_v         (window_v_r),
      .t_in_valid    (tv[k]),
      .t_in_u        (tu_c[k]),
      .t_in_v        (tv_c[k]),
      .t_in_idx      (ti_c[k]),
      .t_out_valid   (tv[k+1]),
      .t_out_u       (tu_c[k+1]),
      .t_out_v       (tv_c[k+1]),
      .t_out_idx     (ti_c[k+1]),
      .res_in_found  (rf[k+1]),
      .res_in_idx    (ri[k+1]),
      .res_in_dist   (rd[k+1]),
      .res_out_found (rf[k]),
      .res_out_idx   (ri[k]),
      .res_out_dist  (rd[k])
    );
  end

  always_ff @(posedge clk) begin
    issue_idx_r <= rd_cnt_r[TAW-1:0];
    if (take_out) begin
      out_r.hit_index      <= IDX_BITS'(out_cnt_r);
      out_r.matched        <= rf[0];
      out_r.truth_index    <= IDX_BITS'(ri[0]);
      out_r.match_distance <= DIST_BITS'(rd[0]);
      out_r.last           <= (out_cnt_r + 1'b1 == hit_cnt_r);
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_u_r  <= WINDOW_RESET;
      window_v_r  <= WINDOW_RESET;
      hit_cnt_r   <= '0;
      truth_cnt_r <= '0;
      rd_cnt_r    <= '0;
      drain_cnt_r <= '0;
      out_cnt_r   <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr == ADDR_WINDOW_U) begin
        window_u_r <= pwdata[WIN_BITS-1:0];
      end
      if (cfg_wr && paddr == ADDR_WINDOW_V) begin
        window_v_r <= pwdata[WIN_BITS-1:0];
      end
      if (take_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      issue_r <= (state_r == S_STREAM) && (rd_cnt_r < truth_cnt_r);
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.operation)
              OP_LOAD_HIT: begin
                if (hit_cnt_r < HCW'(MAX_HITS)) begin
                  hit_cnt_r <= hit_cnt_r + 1'b1;
                end
              end
              OP_LOAD_TRUTH: begin
                if (truth_we) begin
                  truth_cnt_r <= truth_cnt_r + 1'b1;
                end
              end
              OP_RUN: begin
                rd_cnt_r <= '0;
                state_r  <= S_STREAM;
              end
              default: ;
            endcase
          end
        end
        S_STREAM: begin
          if (rd_cnt_r < truth_cnt_r) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end else begin
            drain_cnt_r <= '0;
            state_r     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_cnt_r == DCW'(DRAIN)) begin
            out_cnt_r <= '0;
            state_r   <= S_OUTPUT;
          end else begin
            drain_cnt_r <= drain_cnt_r + 1'b1;
          end
        end
        S_OUTPUT: begin
          if (out_cnt_r == hit_cnt_r) begin
            hit_cnt_r   <= '0;
            truth_cnt_r <= '0;
            state_r     <= S_IDLE;
          end else if (take_out) begin
            out_cnt_r <= out_cnt_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/ghtm_ram.sv
module ghtm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ghtm_cell.sv
module ghtm_cell #(
  parameter int CB  = 24,
  parameter int TAW = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ghtm_pkg::cell_ctl_t               ctl,
  input  logic [CB-1:0]                     load_u,
  input  logic [CB-1:0]                     load_v,
  input  logic [ghtm_pkg::WIN_BITS-1:0]     win_u,
  input  logic [ghtm_pkg::WIN_BITS-1:0]     win_v,
  input  logic                              t_in_valid,
  input  logic [CB-1:0]                     t_in_u,
  input  logic [CB-1:0]                     t_in_v,
  input  logic [TAW-1:0]                    t_in_idx,
  output logic                              t_out_valid,
  output logic [CB-1:0]                     t_out_u,
  output logic [CB-1:0]                     t_out_v,
  output logic [TAW-1:0]                    t_out_idx,
  input  logic                              res_in_found,
  input  logic [TAW-1:0]                    res_in_idx,
  input  logic [((CB + 1 > ghtm_pkg::WIN_BITS) ? CB + 1 : ghtm_pkg::WIN_BITS):0] res_in_dist,
  output logic                              res_out_found,
  output logic [TAW-1:0]                    res_out_idx,
  output logic [((CB + 1 > ghtm_pkg::WIN_BITS) ? CB + 1 : ghtm_pkg::WIN_BITS):0] res_out_dist
);

  import ghtm_pkg::*;

  localparam int DW    = (CB + 1 > WIN_BITS) ? CB + 1 : WIN_BITS;
  localparam int DISTW = DW + 1;

  logic [CB-1:0]    hu_r, hv_r;
  logic             fwd_valid_r;
  logic [CB-1:0]    fwd_u_r, fwd_v_r;
  logic [TAW-1:0]   fwd_idx_r;
  logic             s1_valid_r, s1_pass_r;
  logic [DW-1:0]    s1_tu_r, s1_tv_r;
  logic [TAW-1:0]   s1_idx_r;
  logic             found_r;
  logic [TAW-1:0]   best_idx_r;
  logic [DISTW-1:0] best_r;

  logic [CB:0]      diff_u, diff_v, abs_u, abs_v;
  logic [DW-1:0]    du_w, dv_w, wu_w, wv_w;
  logic             pass_u, pass_v;
  logic [DISTW-1:0] sum;

  always_comb begin
    diff_u = {hu_r[CB-1], hu_r} - {t_in_u[CB-1], t_in_u};
    diff_v = {hv_r[CB-1], hv_r} - {t_in_v[CB-1], t_in_v};
    abs_u  = diff_u[CB] ? -diff_u : diff_u;
    abs_v  = diff_v[CB] ? -diff_v : diff_v;
    du_w   = DW'(abs_u);
    dv_w   = DW'(abs_v);
    wu_w   = DW'(win_u);
    wv_w   = DW'(win_v);
    pass_u = (win_u == '0) || (du_w < wu_w);
    pass_v = (win_v == '0) || (dv_w < wv_w);
    sum    = {1'b0, s1_tu_r} + {1'b0, s1_tv_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hu_r <= load_u;
      hv_r <= load_v;
    end
    fwd_u_r   <= t_in_u;
    fwd_v_r   <= t_in_v;
    fwd_idx_r <= t_in_idx;
    s1_pass_r <= pass_u && pass_v;
    s1_tu_r   <= (win_u == '0) ? '0 : du_w;
    s1_tv_r   <= (win_v == '0) ? '0 : dv_w;
    s1_idx_r  <= t_in_idx;
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      best_r      <= '0;
    end else begin
      fwd_valid_r <= t_in_valid;
      s1_valid_r  <= t_in_valid;
      if (ctl.clear) begin
        found_r    <= 1'b0;
        best_idx_r <= '0;
        best_r     <= '0;
      end else if (ctl.shift) begin
        found_r    <= res_in_found;
        best_idx_r <= res_in_idx;
        best_r     <= res_in_dist;
      end else if (s1_valid_r && s1_pass_r && (!found_r || sum < best_r)) begin
        found_r    <= 1'b1;
        best_idx_r <= s1_idx_r;
        best_r     <= sum;
      end
    end
  end

  assign t_out_valid   = fwd_valid_r;
  assign t_out_u       = fwd_u_r;
  assign t_out_v       = fwd_v_r;
  assign t_out_idx     = fwd_idx_r;
  assign res_out_found = found_r;
  assign res_out_idx   = best_idx_r;
  assign res_out_dist  = best_r;

endmodule
